// ===== sv/lpns_pkg.sv =====
`default_nettype none

package lpns_pkg;

    // Width of one stream word and of the positive magnitude that can be perfect.
    localparam int DATA_WIDTH = 16;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;
    localparam int DIV_WIDTH  = MAG_WIDTH - 1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic        [MAG_WIDTH-1:0]  mag_t;
    typedef logic        [DIV_WIDTH-1:0]  divisor_t;

    // Value reported when no perfect number was seen in the stream.
    localparam data_t NONE_VALUE = '1;

    // Result of one divisor-sum test, from the test unit to the top level.
    typedef struct packed {
        logic done;
        logic perfect;
    } test_status_t;

endpackage

`default_nettype wire

// ===== sv/last_perfect_number_scan.sv =====
`default_nettype none

// Channel   Direction  tdata                        tlast       tuser
// s_        in         [15:0] value                 last_item   -
// m_        out        [15:0] last_perfect          -           [0] found
//
// Negative values, zero and one are rejected without remainder steps; other
// words go to the divisor-sum unit, which does one remainder step per cycle.
// Reset (aresetn, synchronous, active low) clears the scan state and the output
// register. A result waits in the output register while the next word is taken;
// a final word only stalls when the previous result has not been taken.
module last_perfect_number_scan (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire lpns_pkg::data_t       s_tdata,   // [15:0] value
    input  wire logic                  s_tlast,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      lpns_pkg::data_t       m_tdata,   // [15:0] last_perfect
    output      logic                  m_tuser    // [0] found
);
    import lpns_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    data_t        value_reg;
    logic         last_reg;
    data_t        latest_reg;
    logic         seen_reg;
    logic         m_valid_reg;
    data_t        m_data_reg;
    logic         m_found_reg;
    logic         s_accept;
    logic         out_free;
    logic         emit_now;
    test_status_t test_status;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign emit_now = (state_reg == ST_EMIT) && out_free;

    lpns_divsum u_divsum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .value   (s_tdata),
        .status  (test_status)
    );

    // Sequencer: take a word, wait for the test, then emit on the final word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            latest_reg  <= NONE_VALUE;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // Output register: loaded on a final word, emptied when taken.
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        value_reg <= s_tdata;
                        last_reg  <= s_tlast;
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (test_status.done) begin
                        if (test_status.perfect) begin
                            latest_reg <= value_reg;
                            seen_reg   <= 1'b1;
                        end
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_data_reg  <= seen_reg ? latest_reg : NONE_VALUE;
                        m_found_reg <= seen_reg;
                        latest_reg  <= NONE_VALUE;
                        seen_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

endmodule

`default_nettype wire

// ===== sv/lpns_divsum.sv =====
`default_nettype none

module lpns_divsum (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire lpns_pkg::data_t       value,
    output lpns_pkg::test_status_t     status
);
    import lpns_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } state_t;

    state_t       state_reg, state_next;
    mag_t         raw_reg, raw_next;
    divisor_t     half_reg, half_next;
    divisor_t     div_reg, div_next;
    mag_t         quot_reg, quot_next;
    data_t        rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] sum_reg, sum_next;
    test_status_t status_reg, status_next;

    mag_t                  start_raw;
    logic                  start_bad;
    data_t                 div_ext;
    data_t                 quot_ext;
    logic [DATA_WIDTH-1:0] sum_add;
    logic [DATA_WIDTH-1:0] sum_eff;
    logic [DATA_WIDTH-1:0] raw_ext;

    // Negative values, zero and one can never be perfect.
    assign start_raw = value[MAG_WIDTH-1:0];
    assign start_bad = value[DATA_WIDTH-1] || (start_raw <= mag_t'(1));

    assign div_ext  = data_t'({2'b00, div_reg});
    assign quot_ext = data_t'({1'b0, quot_reg});
    assign raw_ext  = {1'b0, raw_reg};
    assign sum_add  = sum_reg + {2'b00, div_reg};
    assign sum_eff  = (rem_reg == '0) ? sum_add : sum_reg;

    // The invariant raw = quot * div + rem is kept with 0 <= rem < div. Moving
    // to the next divisor subtracts the quotient from the remainder; while the
    // remainder is negative, each cycle adds the divisor back and drops the
    // quotient by one. A zero remainder marks a divisor.
    always_comb begin
        state_next  = state_reg;
        raw_next    = raw_reg;
        half_next   = half_reg;
        div_next    = div_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        sum_next    = sum_reg;
        status_next = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (start_bad) begin
                        status_next.done = 1'b1;
                    end else begin
                        raw_next   = start_raw;
                        half_next  = start_raw[MAG_WIDTH-1:1];
                        div_next   = divisor_t'(1);
                        quot_next  = start_raw;
                        rem_next   = '0;
                        sum_next   = '0;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (rem_reg[DATA_WIDTH-1]) begin
                    rem_next  = rem_reg + div_ext;
                    quot_next = quot_reg - mag_t'(1);
                end else if (sum_eff > raw_ext) begin
                    // The sum has passed the value: it cannot come back.
                    status_next.done = 1'b1;
                    state_next       = ST_IDLE;
                end else if (div_reg == half_reg) begin
                    status_next.done    = 1'b1;
                    status_next.perfect = (sum_eff == raw_ext);
                    state_next          = ST_IDLE;
                end else begin
                    sum_next = sum_eff;
                    div_next = div_reg + divisor_t'(1);
                    rem_next = rem_reg - quot_ext;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            status_reg <= '0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
        raw_reg  <= raw_next;
        half_reg <= half_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        sum_reg  <= sum_next;
    end

    assign status = status_reg;

endmodule

`default_nettype wire
